// ===== design/aifp_pkg.sv =====
// Shared types and constants for the ASCII integer field parser.
`default_nettype none

package aifp_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic [1:0] MODE_SIGNED   = 2'd0;
    localparam logic [1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [1:0] MODE_RUNE     = 2'd2;

    localparam logic [20:0] CH_TAB   = 21'h09;
    localparam logic [20:0] CH_LF    = 21'h0A;
    localparam logic [20:0] CH_FF    = 21'h0C;
    localparam logic [20:0] CH_CR    = 21'h0D;
    localparam logic [20:0] CH_SPACE = 21'h20;
    localparam logic [20:0] CH_PLUS  = 21'h2B;
    localparam logic [20:0] CH_MINUS = 21'h2D;
    localparam logic [20:0] CH_0     = 21'h30;
    localparam logic [20:0] CH_7     = 21'h37;
    localparam logic [20:0] CH_9     = 21'h39;
    localparam logic [20:0] CH_UA    = 21'h41;
    localparam logic [20:0] CH_UF    = 21'h46;
    localparam logic [20:0] CH_UX    = 21'h58;
    localparam logic [20:0] CH_LA    = 21'h61;
    localparam logic [20:0] CH_LF_HEX = 21'h66;
    localparam logic [20:0] CH_LX    = 21'h78;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_END       = 2'd2
    } t_status;

    typedef struct packed {
        logic [20:0] character;
        logic        end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [31:0] field_value;
        t_status     status;
        logic [15:0] char_count;
        logic [31:0] line_number;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        in_field;
        logic [15:0] char_index;
        logic        neg;
        t_base       base;
        logic [31:0] acc;
        logic        line_inc;
        logic        emit;
        logic [31:0] value;
        t_status     status;
        logic [15:0] count;
        logic        again;
    } t_step;

endpackage

`default_nettype wire

// ===== design/ascii_integer_field_parser.sv =====
// ASCII integer field parser: one character per transaction, fields out through a queue.
// Each result is registered into the output queue when its input transaction is accepted.
// Throughput: one character per cycle while the input is not stalled; a character that ends a
// field and starts the next one gives two results, which leave the output queue in turn.
// Input stalls while the output queue holds more than QUEUE_DEPTH-2 results.
// Reset (synchronous, active low) clears mode, parse state, line count and the queue.
`default_nettype none

module ascii_integer_field_parser
    import aifp_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]  r_mode;
    logic        r_in_field, n_in_field;
    logic [15:0] r_char_index, n_char_index;
    logic        r_neg, n_neg;
    t_base       r_base, n_base;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_line, n_line;

    t_out_item   r_queue [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;

    logic      accept, pop, wr0, wr1;
    t_step     step_a, step_b;
    t_out_item item0, item1;

    function automatic t_step field_step(
        input logic        in_f,
        input logic [15:0] idx_in,
        input logic        neg_in,
        input t_base       base_in,
        input logic [31:0] acc_in,
        input logic [20:0] c,
        input logic [1:0]  mode
    );
        t_step       s;
        logic [15:0] idx;
        logic        blank;
        logic        consumed;
        logic        dig_ok;
        logic [3:0]  dig;
        logic [31:0] mul;
        s.in_field   = in_f;
        s.char_index = idx_in;
        s.neg        = neg_in;
        s.base       = base_in;
        s.acc        = acc_in;
        s.line_inc   = 1'b0;
        s.emit       = 1'b0;
        s.value      = '0;
        s.status     = ST_OK;
        s.count      = '0;
        s.again      = 1'b0;
        idx          = idx_in;
        consumed     = 1'b0;
        dig_ok       = 1'b0;
        dig          = '0;
        mul          = '0;
        blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                (c == CH_CR) || (c == CH_FF);
        if (!in_f && blank) begin
            s.line_inc = (c == CH_LF);
        end else if (!in_f && mode == MODE_RUNE) begin
            s.emit   = 1'b1;
            s.value  = {11'd0, c};
            s.status = ST_OK;
            s.count  = 16'd1;
        end else begin
            if (!in_f) begin
                s.in_field = 1'b1;
                idx        = '0;
                s.neg      = 1'b0;
                s.base     = BASE_DEC;
                s.acc      = '0;
            end
            s.char_index = (idx != COUNT_MAX) ? idx + 16'd1 : idx;
            if (idx == 16'd0) begin
                if (mode == MODE_SIGNED && c == CH_MINUS) begin
                    s.neg    = 1'b1;
                    consumed = 1'b1;
                end else if (mode == MODE_SIGNED && c == CH_PLUS) begin
                    consumed = 1'b1;
                end else if (c == CH_0) begin
                    s.base   = BASE_OCT;
                    consumed = 1'b1;
                end
            end else if (idx == 16'd1) begin
                if ((c == CH_LX || c == CH_UX) && s.base == BASE_OCT) begin
                    s.base   = BASE_HEX;
                    consumed = 1'b1;
                end
            end
            if (!consumed) begin
                if (c >= CH_0 && c <= CH_9) begin
                    dig_ok = !(s.base == BASE_OCT && c > CH_7);
                    dig    = c[3:0];
                end else if (s.base == BASE_HEX &&
                             ((c >= CH_LA && c <= CH_LF_HEX) ||
                              (c >= CH_UA && c <= CH_UF))) begin
                    dig_ok = 1'b1;
                    dig    = 4'd9 + c[3:0];
                end
                if (dig_ok) begin
                    unique case (s.base)
                        BASE_HEX: mul = {s.acc[27:0], 4'd0};
                        BASE_OCT: mul = {s.acc[28:0], 3'd0};
                        default:  mul = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0};
                    endcase
                    s.acc = mul + {28'd0, dig};
                end else begin
                    s.emit     = 1'b1;
                    s.value    = s.neg ? (32'd0 - s.acc) : s.acc;
                    s.status   = (s.char_index == 16'd1) ? ST_NO_DIGITS : ST_OK;
                    s.count    = s.char_index;
                    s.in_field = 1'b0;
                    s.again    = (s.char_index != 16'd1);
                end
            end
        end
        return s;
    endfunction

    assign o_in_stall  = (r_count > CW'(QUEUE_DEPTH - 2));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_queue[r_rp];
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        step_a = field_step(r_in_field, r_char_index, r_neg, r_base, r_acc,
                            i_in_data.character, r_mode);
        step_b = field_step(1'b0, step_a.char_index, step_a.neg, step_a.base,
                            step_a.acc, i_in_data.character, r_mode);

        n_in_field   = r_in_field;
        n_char_index = r_char_index;
        n_neg        = r_neg;
        n_base       = r_base;
        n_acc        = r_acc;
        n_line       = r_line;
        wr0          = 1'b0;
        wr1          = 1'b0;

        item0.field_value = step_a.value;
        item0.status      = step_a.status;
        item0.char_count  = step_a.count;
        item0.line_number = r_line;
        item0.last        = !(step_a.again && step_b.emit);
        item1.field_value = step_b.value;
        item1.status      = step_b.status;
        item1.char_count  = step_b.count;
        item1.line_number = r_line;
        item1.last        = 1'b1;

        if (accept) begin
            if (i_in_data.end_of_input) begin
                n_in_field        = 1'b0;
                wr0               = 1'b1;
                item0.field_value = '0;
                item0.status      = ST_END;
                item0.char_count  = '0;
                item0.last        = 1'b1;
            end else if (step_a.again) begin
                n_in_field   = step_b.in_field;
                n_char_index = step_b.char_index;
                n_neg        = step_b.neg;
                n_base       = step_b.base;
                n_acc        = step_b.acc;
                n_line       = r_line + {31'd0, step_b.line_inc};
                wr0          = 1'b1;
                wr1          = step_b.emit;
            end else begin
                n_in_field   = step_a.in_field;
                n_char_index = step_a.char_index;
                n_neg        = step_a.neg;
                n_base       = step_a.base;
                n_acc        = step_a.acc;
                n_line       = r_line + {31'd0, step_a.line_inc};
                wr0          = step_a.emit;
            end
        end

        n_wp    = r_wp + PW'(wr0) + PW'(wr1);
        n_rp    = r_rp + PW'(pop);
        n_count = r_count + CW'(wr0) + CW'(wr1) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SIGNED;
            r_in_field   <= 1'b0;
            r_char_index <= '0;
            r_neg        <= 1'b0;
            r_base       <= BASE_DEC;
            r_acc        <= '0;
            r_line       <= '0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_in_field   <= n_in_field;
            r_char_index <= n_char_index;
            r_neg        <= n_neg;
            r_base       <= n_base;
            r_acc        <= n_acc;
            r_line       <= n_line;
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (wr0 && PW'(i) == r_wp) begin
                r_queue[i] <= item0;
            end else if (wr1 && PW'(i) == PW'(r_wp + PW'(1))) begin
                r_queue[i] <= item1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/aifp_checker.sv =====
// Port-level assertions for the ASCII integer field parser, bound to the top level.
`default_nettype none

module aifp_checker
    import aifp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.end_of_input |=> o_out_valid)
        else $error("end of input gave no result");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_END |->
            o_out_data.last && o_out_data.field_value == 32'd0 &&
            o_out_data.char_count == 16'd0)
        else $error("bad end of input result");

    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NO_DIGITS |->
            o_out_data.last && o_out_data.char_count == 16'd1)
        else $error("bad no digits result");

endmodule

bind ascii_integer_field_parser aifp_checker u_aifp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== verif/ascii_integer_field_parser_test.sv =====
// Self-checking testbench for the ASCII integer field parser: directed and random character streams.
`timescale 1ns / 100ps

module ascii_integer_field_parser_test;
    import aifp_pkg::*;

    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam logic [20:0] CH_LG       = 21'h67;
    localparam logic [20:0] CH_LZ       = 21'h7A;
    localparam logic [20:0] CH_TOP      = 21'h10FFFF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 55;

    class parsed_field_scoreboard;
        logic [1:0]  field_mode;
        logic        in_field;
        logic [15:0] char_index;
        logic        neg;
        t_base       base;
        logic [31:0] acc;
        logic [31:0] line_count;
        t_out_item   pending_fields[$];
        int          mismatches;

        function new();
            field_mode = MODE_SIGNED;
            in_field   = 1'b0;
            char_index = '0;
            neg        = 1'b0;
            base       = BASE_DEC;
            acc        = '0;
            line_count = '0;
            mismatches = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            field_mode = m;
        endfunction

        function int pending();
            return pending_fields.size();
        endfunction

        static function bit is_blank(logic [20:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
        endfunction

        static function int digit_value(logic [20:0] c, t_base b);
            if (c >= CH_0 && c <= CH_9) begin
                if (b == BASE_OCT && c > CH_7) return -1;
                return int'(c - CH_0);
            end
            if (b == BASE_HEX) begin
                if (c >= CH_LA && c <= CH_LF_HEX) return 10 + int'(c - CH_LA);
                if (c >= CH_UA && c <= CH_UF) return 10 + int'(c - CH_UA);
            end
            return -1;
        endfunction

        function t_out_item make_field(logic [31:0] v, t_status s, logic [15:0] cnt);
            t_out_item r;
            r.field_value = v;
            r.status      = s;
            r.char_count  = cnt;
            r.line_number = line_count;
            r.last        = 1'b0;
            return r;
        endfunction

        // Predicts the fields that one accepted transaction produces.
        function void note_char(t_in_item it);
            t_out_item   res[2];
            int          n;
            logic [20:0] c;
            logic [15:0] idx;
            logic [31:0] mul;
            int          d;
            bit          again;
            n = 0;
            c = it.character;
            if (it.end_of_input) begin
                in_field = 1'b0;
                res[0] = make_field('0, ST_END, '0);
                n = 1;
            end else begin
                again = 1'b1;
                while (again) begin
                    again = 1'b0;
                    if (!in_field) begin
                        if (is_blank(c)) begin
                            if (c == CH_LF) line_count++;
                            break;
                        end
                        if (field_mode == MODE_RUNE) begin
                            res[n] = make_field({11'd0, c}, ST_OK, 16'd1);
                            n++;
                            break;
                        end
                        in_field   = 1'b1;
                        char_index = '0;
                        neg        = 1'b0;
                        base       = BASE_DEC;
                        acc        = '0;
                    end
                    idx = char_index;
                    if (char_index != COUNT_MAX) char_index++;
                    if (idx == 0 && field_mode == MODE_SIGNED && (c == CH_MINUS || c == CH_PLUS))
                    begin
                        neg = (c == CH_MINUS);
                    end else if (idx == 0 && c == CH_0) begin
                        base = BASE_OCT;
                    end else if (idx == 1 && (c == CH_LX || c == CH_UX) && base == BASE_OCT)
                    begin
                        base = BASE_HEX;
                    end else begin
                        d = digit_value(c, base);
                        if (d >= 0) begin
                            mul = (base == BASE_HEX) ? 32'd16 : (base == BASE_OCT ? 32'd8 : 32'd10);
                            acc = acc * mul + 32'(d);
                        end else begin
                            res[n] = make_field(neg ? (32'd0 - acc) : acc,
                                                (char_index == 16'd1) ? ST_NO_DIGITS : ST_OK,
                                                char_index);
                            n++;
                            in_field = 1'b0;
                            again = (char_index != 16'd1);
                        end
                    end
                end
            end
            if (n > 0) res[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++) pending_fields.push_back(res[i]);
        endfunction

        function void check_field(t_out_item got);
            t_out_item want;
            if (pending_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected field: value=%h status=%0d count=%0d line=%0d last=%0b",
                             got.field_value, got.status, got.char_count, got.line_number,
                             got.last);
                return;
            end
            want = pending_fields.pop_front();
            if (got.field_value !== want.field_value || got.status !== want.status ||
                got.char_count !== want.char_count || got.line_number !== want.line_number ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp value=%h status=%0d count=%0d line=%0d last=%0b",
                             want.field_value, want.status, want.char_count,
                             want.line_number, want.last);
                    $display("          got value=%h status=%0d count=%0d line=%0d last=%0b",
                             got.field_value, got.status, got.char_count,
                             got.line_number, got.last);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    parsed_field_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct = 0;
    logic hold_start = 1'b0;
    logic hold_taken = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  chars_sent = 0;
    logic [1:0] mode_cycle[4] = '{MODE_SIGNED, MODE_UNSIGNED, MODE_RUNE, MODE_SPARE};

    ascii_integer_field_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: random stall plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_field(o_out_data);
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_char(it);
        if (it.end_of_input || !parsed_field_scoreboard::is_blank(it.character)) chars_sent++;
    endtask

    task automatic send_char(input logic [20:0] c);
        t_in_item it;
        it.character    = c;
        it.end_of_input = 1'b0;
        send_item(it);
    endtask

    task automatic send_end();
        t_in_item it;
        it.character    = 21'($urandom_range(CH_TOP));
        it.end_of_input = 1'b1;
        send_item(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        sb.set_mode(m);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [20:0] random_blank();
        case ($urandom_range(4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [20:0] random_digit(input t_base b);
        case (b)
            BASE_OCT: return CH_0 + 21'($urandom_range(7));
            BASE_HEX: begin
                case ($urandom_range(2))
                    0: return CH_0 + 21'($urandom_range(9));
                    1: return CH_LA + 21'($urandom_range(5));
                    default: return CH_UA + 21'($urandom_range(5));
                endcase
            end
            default: return CH_0 + 21'($urandom_range(9));
        endcase
    endfunction

    function automatic logic [20:0] random_char();
        case ($urandom_range(6))
            0: return random_digit(BASE_DEC);
            1: return random_digit(BASE_HEX);
            2: return $urandom_range(1) ? CH_LX : CH_UX;
            3: return $urandom_range(1) ? CH_MINUS : CH_PLUS;
            4: return random_blank();
            5: return 21'h21 + 21'($urandom_range(93));
            default: return 21'($urandom_range(CH_TOP));
        endcase
    endfunction

    task automatic send_number();
        t_base b;
        int    len;
        repeat ($urandom_range(2)) send_char(random_blank());
        if ($urandom_range(2) == 0) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
        b   = t_base'($urandom_range(2));
        len = $urandom_range(11);
        if (b != BASE_DEC) send_char(CH_0);
        if (b == BASE_HEX) send_char($urandom_range(1) ? CH_LX : CH_UX);
        if (b == BASE_DEC) send_char(CH_0 + 21'($urandom_range(1, 9)));
        repeat (len) send_char(random_digit(b));
        case ($urandom_range(2))
            0: send_char(random_blank());
            1: send_char(random_char());
            default: send_char(b == BASE_HEX ? CH_LG : (b == BASE_OCT ? CH_9 : CH_LA));
        endcase
    endtask

    task automatic send_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_number();
        end else if (pick < 78) begin
            send_end();
        end else begin
            repeat ($urandom_range(1, 4)) send_char(random_char());
        end
    endtask

    initial begin
        int target;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = MODE_SIGNED;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        send_idle_pct = 18;
        recv_idle_pct = 56;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_SIGNED);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(CH_LF);
        send_char(CH_CR);
        send_char(CH_FF);
        // sign before a zero keeps decimal, so the x ends the field; the newline is counted
        send_char(CH_MINUS);
        send_char(CH_0);
        send_char(CH_LX);
        send_char(CH_LF_HEX);
        send_char(CH_UF);
        send_char(CH_LF);
        // signed decimal ended by a non-digit that is then itself a no-digit field
        send_char(CH_PLUS);
        send_char(CH_0);
        send_char(CH_7);
        send_char(CH_9);
        send_char(CH_LZ);
        send_char(CH_MINUS);
        send_char(CH_LG);
        send_char(CH_TOP);
        // mode switched to rune while a number is open
        send_char(CH_9);
        write_mode(MODE_RUNE);
        send_char(CH_SPACE);
        send_char(CH_TOP);
        write_mode(MODE_SIGNED);
        send_char(CH_0);
        send_char(CH_UX);
        send_end();

        for (int p = 0; p < 3; p++) begin
            for (int m = 0; m < 4; m++) begin
                write_mode(mode_cycle[m]);
                if (m == 0) begin
                    send_idle_pct = (p == 0) ? 18 : (p == 1 ? 56 : 0);
                    recv_idle_pct <= (p == 0) ? 56 : (p == 1 ? 18 : 0);
                    if (p == 2) hold_start <= 1'b1;
                end
                target = chars_sent + PHASE_ITEMS;
                while (chars_sent < target) send_token();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
